FILE: hw/rtl/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg: shared definitions for the pixel format converter
// Mode codes, channel rescale tables and rounding helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package pfc_pkg;

   // conversion mode codes
   localparam logic [2:0] MODE_565_TO_8888  = 3'd0;
   localparam logic [2:0] MODE_4444_TO_8888 = 3'd1;
   localparam logic [2:0] MODE_5551_TO_8888 = 3'd2;
   localparam logic [2:0] MODE_888_TO_8888  = 3'd3;
   localparam logic [2:0] MODE_8888_TO_565  = 3'd4;
   localparam logic [2:0] MODE_8888_TO_4444 = 3'd5;
   localparam logic [2:0] MODE_8888_TO_5551 = 3'd6;

   localparam int unsigned PIXEL_W = 32;
   localparam int unsigned MODE_W  = 3;

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef logic [MODE_W-1:0]  mode_type;

   typedef logic [7:0] exp5_tbl_type [32];
   typedef logic [7:0] exp6_tbl_type [64];

   // rounded expansion tables, built at elaboration
   function automatic exp5_tbl_type build_exp5();
      exp5_tbl_type t;
      for (int i = 0; i < 32; i++) begin
         t[i] = 8'((i * 255 + 15) / 31);
      end
      return t;
   endfunction

   function automatic exp6_tbl_type build_exp6();
      exp6_tbl_type t;
      for (int i = 0; i < 64; i++) begin
         t[i] = 8'((i * 255 + 31) / 63);
      end
      return t;
   endfunction

   localparam exp5_tbl_type EXP5_TBL = build_exp5();
   localparam exp6_tbl_type EXP6_TBL = build_exp6();

   // floor(x / 255), exact for x below 65280
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + 17'd1 + {9'b0, x[15:8]};
      return t[15:8];
   endfunction

   // round an 8-bit channel down to a range of 0..dmax
   function automatic logic [5:0] reduce8(input logic [7:0] v, input logic [5:0] dmax);
      logic [15:0] x;
      logic [7:0]  q;
      // widen both factors so the full product is kept
      x = ({8'd0, v} * {10'd0, dmax}) + 16'd127;
      q = div255(x);
      return q[5:0];
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pfc_csr.sv
// ----------------------------------------------------------------------------
// pfc_csr: configuration register file
// Holds the conversion mode, written and read over an APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_csr (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [2:0]        csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic      [31:0]       csr_prdata,
   output logic                   csr_pready,
   output pfc_pkg::mode_type      mode
);
   import pfc_pkg::*;

   localparam logic REG_MODE = 1'b0;

   mode_type mode_ff;
   mode_type mode_in;
   logic     wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // write the mode register on the access cycle
   always_comb begin
      mode_in = mode_ff;
      if (wr_en && (csr_paddr[2] == REG_MODE)) begin
         mode_in = csr_pwdata[MODE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_565_TO_8888;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // read back; unmapped addresses return zero
   assign csr_prdata = (csr_paddr[2] == REG_MODE) ? {{(32-MODE_W){1'b0}}, mode_ff} : 32'd0;
   assign mode = mode_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/pfc_convert.sv
// ----------------------------------------------------------------------------
// pfc_convert: pixel conversion datapath
// Unpacks the source word, rescales each channel with rounding and repacks.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_convert (
   input  pfc_pkg::pixel_type px_in,
   input  pfc_pkg::mode_type  mode,
   output pfc_pkg::pixel_type px_out
);
   import pfc_pkg::*;

   logic [7:0] r8, g8, b8, a8;
   logic [5:0] r5, g6, b5, g5;
   logic [5:0] r4, g4, b4, a4;
   logic [3:0] s_r4, s_g4, s_b4, s_a4;

   assign r8 = px_in[7:0];
   assign g8 = px_in[15:8];
   assign b8 = px_in[23:16];
   assign a8 = px_in[31:24];

   // reduction terms for the three narrowing modes
   assign r5 = reduce8(r8, 6'd31);
   assign g6 = reduce8(g8, 6'd63);
   assign g5 = reduce8(g8, 6'd31);
   assign b5 = reduce8(b8, 6'd31);
   assign r4 = reduce8(r8, 6'd15);
   assign g4 = reduce8(g8, 6'd15);
   assign b4 = reduce8(b8, 6'd15);
   assign a4 = reduce8(a8, 6'd15);

   // 4-bit source channels expand exactly by nibble replication
   assign s_r4 = px_in[15:12];
   assign s_g4 = px_in[11:8];
   assign s_b4 = px_in[7:4];
   assign s_a4 = px_in[3:0];

   always_comb begin
      unique case (mode)
         MODE_565_TO_8888: begin
            px_out = {8'hFF, EXP5_TBL[px_in[4:0]], EXP6_TBL[px_in[10:5]],
                      EXP5_TBL[px_in[15:11]]};
         end
         MODE_4444_TO_8888: begin
            px_out = {s_a4, s_a4, s_b4, s_b4, s_g4, s_g4, s_r4, s_r4};
         end
         MODE_5551_TO_8888: begin
            px_out = {{8{px_in[0]}}, EXP5_TBL[px_in[5:1]], EXP5_TBL[px_in[10:6]],
                      EXP5_TBL[px_in[15:11]]};
         end
         MODE_888_TO_8888: begin
            px_out = {8'hFF, px_in[23:0]};
         end
         MODE_8888_TO_565: begin
            px_out = {16'd0, r5[4:0], g6[5:0], b5[4:0]};
         end
         MODE_8888_TO_4444: begin
            px_out = {16'd0, r4[3:0], g4[3:0], b4[3:0], a4[3:0]};
         end
         MODE_8888_TO_5551: begin
            // one-bit alpha rounds up from the midpoint
            px_out = {16'd0, r5[4:0], g5[4:0], b5[4:0], a8[7]};
         end
         default: begin
            px_out = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: hw/rtl/pixel_format_converter_core.sv
// ----------------------------------------------------------------------------
// pixel_format_converter_core: streaming pixel format converter
// One pixel word in, one converted pixel word out, under a mode register.
//
//   channel   direction  width  contents
//   req_*     in         32     source pixel word
//   rsp_*     out        32     converted pixel word
//   csr_*     in/out     32     conversion mode register at byte address 0
//
// One item per cycle sustained while results are taken; an accepted item passes
// through the input register and then the result register around the datapath.
// Synchronous reset empties both registers and sets mode 0.
// A stalled result holds in the result register while the input register
// still takes one more item; ready falls only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_format_converter_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,    // [31:0] pixel_in
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,    // [31:0] pixel_out
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import pfc_pkg::*;

   mode_type  mode;
   pixel_type conv_px;

   logic      in_valid_ff, in_valid_in;
   pixel_type in_px_ff, in_px_in;
   logic      rsp_valid_ff, rsp_valid_in;
   pixel_type rsp_px_ff, rsp_px_in;
   logic      req_fire;
   logic      rsp_load;

   pfc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .mode        (mode)
   );

   pfc_convert u_convert (
      .px_in  (in_px_ff),
      .mode   (mode),
      .px_out (conv_px)
   );

   // advance the input item when the result register is free or draining
   assign rsp_load   = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || rsp_load;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_px_in    = in_px_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_px_in    = req_tdata;
      end else if (rsp_load) begin
         in_valid_in = 1'b0;
      end
   end

   // hold the result until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_px_in    = rsp_px_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_px_in    = conv_px;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_px_ff  <= in_px_in;
      rsp_px_ff <= rsp_px_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_px_ff;

   // an accepted item lands in the input register
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> in_valid_ff)
      else $error("accepted item missing from input register");

   // an input item moves into an empty result register
   a_advance: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("input item did not advance to result register");

   // a stalled output keeps the waiting input item
   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && !rsp_tready) |=> in_valid_ff)
      else $error("input item dropped while output stalled");

   // reset leaves the pipe empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!in_valid_ff && !rsp_valid_ff))
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

FILE: tb/pfc_stream_checker.sv
// ----------------------------------------------------------------------------
// pfc_stream_checker: result checker for the pixel format converter
// Follows the mode register through the configuration port, converts every
// accepted source pixel itself and matches each delivered pixel in order.
// ----------------------------------------------------------------------------

module pfc_stream_checker #(
   parameter logic [2:0] MODE_ADDR = 3'd0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,    // [31:0] pixel_in
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,    // [31:0] pixel_out
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending_count
);
   import pfc_pkg::*;

   typedef struct {
      pixel_type source;
      mode_type  mode;
      pixel_type converted;
   } converted_pixel_type;

   converted_pixel_type expected_pixels[$];
   mode_type            active_mode;

   // rounded rescale of one channel from 0..src_max to 0..dst_max
   function automatic int unsigned scale_channel(int unsigned v, int unsigned src_max,
                                                 int unsigned dst_max);
      return (v * dst_max + src_max / 2) / src_max;
   endfunction

   // RGBA8888 words carry red in byte 0 and alpha in byte 3
   function automatic pixel_type convert_pixel(pixel_type px, mode_type mode);
      logic [7:0] r8, g8, b8, a8;
      r8 = px[7:0];
      g8 = px[15:8];
      b8 = px[23:16];
      a8 = px[31:24];
      case (mode)
         MODE_565_TO_8888: begin
            return {8'hFF, 8'(scale_channel(px[4:0], 31, 255)),
                    8'(scale_channel(px[10:5], 63, 255)),
                    8'(scale_channel(px[15:11], 31, 255))};
         end
         MODE_4444_TO_8888: begin
            return {8'(scale_channel(px[3:0], 15, 255)), 8'(scale_channel(px[7:4], 15, 255)),
                    8'(scale_channel(px[11:8], 15, 255)),
                    8'(scale_channel(px[15:12], 15, 255))};
         end
         MODE_5551_TO_8888: begin
            return {8'(scale_channel(px[0], 1, 255)), 8'(scale_channel(px[5:1], 31, 255)),
                    8'(scale_channel(px[10:6], 31, 255)),
                    8'(scale_channel(px[15:11], 31, 255))};
         end
         MODE_888_TO_8888: begin
            return {8'hFF, px[23:0]};
         end
         MODE_8888_TO_565: begin
            return {16'h0000, 5'(scale_channel(r8, 255, 31)), 6'(scale_channel(g8, 255, 63)),
                    5'(scale_channel(b8, 255, 31))};
         end
         MODE_8888_TO_4444: begin
            return {16'h0000, 4'(scale_channel(r8, 255, 15)), 4'(scale_channel(g8, 255, 15)),
                    4'(scale_channel(b8, 255, 15)), 4'(scale_channel(a8, 255, 15))};
         end
         MODE_8888_TO_5551: begin
            return {16'h0000, 5'(scale_channel(r8, 255, 31)), 5'(scale_channel(g8, 255, 31)),
                    5'(scale_channel(b8, 255, 31)), 1'(scale_channel(a8, 255, 1))};
         end
         default: begin
            return '0;
         end
      endcase
   endfunction

   // track the mode, queue a conversion per accepted item, match results in order
   always @(posedge clock) begin
      converted_pixel_type want;
      if (reset) begin
         expected_pixels.delete();
         active_mode = MODE_565_TO_8888;
         fail_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == MODE_ADDR) begin
            active_mode = csr_pwdata[MODE_W-1:0];
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("unexpected pixel item %h", rsp_tdata);
               end
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_tdata !== want.converted) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("pixel mismatch: mode %0d source %h expected %h got %h",
                              want.mode, want.source, want.converted, rsp_tdata);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            want.source = req_tdata;
            want.mode = active_mode;
            want.converted = convert_pixel(req_tdata, active_mode);
            expected_pixels.push_back(want);
         end
      end
      pending_count = expected_pixels.size();
   end

endmodule

FILE: tb/tb_pixel_format_converter_core.sv
// ----------------------------------------------------------------------------
// tb_pixel_format_converter_core: testbench for the pixel format converter
// Walks every mode code with corner pixels, then runs random pixel phases
// under changing modes with random stalls on both channels and one long
// result back-pressure. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------

module tb_pixel_format_converter_core;
   import pfc_pkg::*;

   localparam logic [2:0] MODE_ADDR       = 3'd0;
   localparam logic [2:0] UNMAPPED_ADDR   = 3'd4;
   localparam mode_type   MODE_UNDEFINED  = 3'd7;
   localparam int         NUM_MODE_CODES  = 1 << MODE_W;
   localparam int         NUM_PHASES      = 14;
   localparam int         ITEMS_PER_PHASE = 125;
   localparam int         QUIET_PHASE     = 5;
   localparam int         HOLD_OFF_PHASE  = 3;
   localparam int         HOLD_OFF_CYCLES = 300;
   localparam int         CYCLE_LIMIT     = 500000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count;
   int pending_count;
   int cycle_count = 0;
   bit idle_on = 1'b0;
   bit hold_off_req = 1'b0;

   pixel_format_converter_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   pfc_stream_checker #(.MODE_ADDR(MODE_ADDR)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // end the run if it hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic mode_type pick_mode(int idx);
      case (idx)
         0: return MODE_565_TO_8888;
         1: return MODE_4444_TO_8888;
         2: return MODE_5551_TO_8888;
         3: return MODE_888_TO_8888;
         4: return MODE_8888_TO_565;
         5: return MODE_8888_TO_4444;
         6: return MODE_8888_TO_5551;
         default: return MODE_UNDEFINED;
      endcase
   endfunction

   // random word, sometimes with bytes forced to all zeros or all ones
   function automatic pixel_type random_pixel();
      pixel_type px;
      px = $urandom;
      if ($urandom_range(0, 3) == 0) begin
         for (int i = 0; i < 4; i++) begin
            case ($urandom_range(0, 2))
               0: px[8*i +: 8] = 8'h00;
               1: px[8*i +: 8] = 8'hFF;
               default: ;
            endcase
         end
      end
      return px;
   endfunction

   // setup cycle, then access cycle until pready
   task automatic write_csr(input logic [2:0] addr, input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // offer one item, with an optional idle burst ahead of it
   task automatic send_pixel(input pixel_type px);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= px;
      do @(posedge clock); while (!req_tready);
   endtask

   // step once first so the last accepted item is already counted
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // result side: random stall bursts, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      mode_type    phase_mode;
      logic [31:0] csr_word;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // corner pixels under every mode code; the first pass runs on the reset mode
      for (int m = 0; m < NUM_MODE_CODES; m++) begin
         if (m != 0) begin
            write_csr(MODE_ADDR, 32'(pick_mode(m)));
         end
         send_pixel(32'h0000_0000);
         send_pixel(32'hFFFF_FFFF);
         send_pixel(32'h807F_01FE);
         drain_results();
      end

      // a write past the register list must leave the mode alone
      write_csr(UNMAPPED_ADDR, '0);
      send_pixel(32'h1234_5678);
      send_pixel(32'hFEDC_BA98);
      drain_results();

      // random phases, one mode each; idling stops near the end
      for (int p = 0; p < NUM_PHASES; p++) begin
         idle_on = (p != QUIET_PHASE) && (p < NUM_PHASES - 2);
         phase_mode = (p < NUM_MODE_CODES) ? pick_mode(p)
                                           : pick_mode($urandom_range(0, NUM_MODE_CODES - 1));
         csr_word = $urandom;
         csr_word[MODE_W-1:0] = phase_mode;
         write_csr(MODE_ADDR, csr_word);
         if (p % 3 == 1) begin
            write_csr(UNMAPPED_ADDR, $urandom);
         end
         if (p == HOLD_OFF_PHASE) begin
            hold_off_req = 1'b1;
         end
         repeat (ITEMS_PER_PHASE) send_pixel(random_pixel());
         drain_results();
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
